// ----- design/sma_pkg.sv -----
package sma_pkg;

  // Operation codes carried on the input channel.
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } sma_op_t;

  // Ordering codes returned by compare.
  localparam logic [1:0] ORD_LESS      = 2'd0;
  localparam logic [1:0] ORD_EQUAL     = 2'd1;
  localparam logic [1:0] ORD_GREATER   = 2'd2;
  localparam logic [1:0] ORD_UNORDERED = 2'd3;

  // Width of the magnitude ports.
  localparam int unsigned PORT_BITS = 64;

  // Opcode and operand flags that travel along the cell row.
  typedef struct packed {
    logic [2:0] op;
    logic       a_pos;
    logic       a_nan;
    logic       a_inf;
    logic       b_pos;
    logic       b_nan;
    logic       b_inf;
  } sma_ctl_t;

endpackage

// ----- design/sma_cell.sv -----
module sma_cell #(
  parameter int unsigned W   = 64,
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  sma_pkg::sma_ctl_t up_ctl,
  input  logic [W-1:0]      up_a,
  input  logic [W-1:0]      up_b,
  input  logic [W-1:0]      up_acc,
  input  logic [W-1:0]      up_q,
  input  logic [W-1:0]      up_ash,
  input  logic              up_sh_ovf,
  input  logic              up_ovf,
  output logic              dn_valid,
  input  logic              dn_ready,
  output sma_pkg::sma_ctl_t dn_ctl,
  output logic [W-1:0]      dn_a,
  output logic [W-1:0]      dn_b,
  output logic [W-1:0]      dn_acc,
  output logic [W-1:0]      dn_q,
  output logic [W-1:0]      dn_ash,
  output logic              dn_sh_ovf,
  output logic              dn_ovf
);
  import sma_pkg::*;

  logic              valid_r;
  sma_ctl_t          ctl_r;
  logic [W-1:0]      a_r, b_r, acc_r, q_r, ash_r;
  logic              sh_ovf_r, ovf_r;
  logic [W-1:0]      acc_nxt, q_nxt, ash_nxt;
  logic              sh_ovf_nxt, ovf_nxt;
  logic [W:0]        sum;
  logic [W:0]        trial;
  logic [W:0]        diff;
  logic              qbit;

  // The stage takes a new transfer when empty or when its content moves on.
  assign up_ready = !valid_r || dn_ready;

  // One step of shift-and-add multiply and one step of restoring divide.
  always_comb begin
    sum        = {1'b0, up_acc} + {1'b0, up_ash};
    trial      = {up_acc, up_a[W-1-IDX]};
    diff       = trial - {1'b0, up_b};
    qbit       = (trial >= {1'b0, up_b});
    q_nxt      = {up_q[W-2:0], qbit};
    ash_nxt    = {up_ash[W-2:0], 1'b0};
    sh_ovf_nxt = up_sh_ovf | up_ash[W-1];
    ovf_nxt    = up_ovf;
    acc_nxt    = up_acc;
    if (up_ctl.op == OP_MUL) begin
      if (up_b[IDX]) begin
        acc_nxt = sum[W-1:0];
        ovf_nxt = up_ovf | sum[W] | up_sh_ovf;
      end
    end else begin
      acc_nxt = qbit ? diff[W-1:0] : trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctl_r    <= up_ctl;
      a_r      <= up_a;
      b_r      <= up_b;
      acc_r    <= acc_nxt;
      q_r      <= q_nxt;
      ash_r    <= ash_nxt;
      sh_ovf_r <= sh_ovf_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_ctl    = ctl_r;
  assign dn_a      = a_r;
  assign dn_b      = b_r;
  assign dn_acc    = acc_r;
  assign dn_q      = q_r;
  assign dn_ash    = ash_r;
  assign dn_sh_ovf = sh_ovf_r;
  assign dn_ovf    = ovf_r;

endmodule

// ----- design/sma_fin.sv -----
module sma_fin #(
  parameter int unsigned W = 64
) (
  input  sma_pkg::sma_ctl_t ctl,
  input  logic [W-1:0]      a_mag,
  input  logic [W-1:0]      b_mag,
  input  logic [W-1:0]      prod,
  input  logic              prod_ovf,
  input  logic [W-1:0]      quot,
  output logic [W-1:0]      r_mag,
  output logic              r_pos,
  output logic              r_nan,
  output logic              r_inf,
  output logic [1:0]        order
);
  import sma_pkg::*;

  logic         bpe;
  logic         any_flag;
  logic         a_zero, b_zero;
  logic [W:0]   sum;
  logic         a_lt_b;
  logic [W-1:0] mag;
  logic         pos, nan, inf;

  // Effective sign of b: subtract flips it and keeps its flags.
  assign bpe      = (ctl.op == OP_SUB) ? !ctl.b_pos : ctl.b_pos;
  assign any_flag = ctl.a_nan | ctl.a_inf | ctl.b_nan | ctl.b_inf;
  assign a_zero   = (a_mag == '0);
  assign b_zero   = (b_mag == '0);
  assign sum      = {1'b0, a_mag} + {1'b0, b_mag};
  assign a_lt_b   = (a_mag < b_mag);

  // Arithmetic result before the special-value cleanup.
  always_comb begin
    mag = a_mag;
    pos = ctl.a_pos;
    nan = 1'b0;
    inf = 1'b0;
    case (ctl.op)
      OP_ADD, OP_SUB: begin
        if (any_flag) begin
          nan = ctl.a_nan | ctl.b_nan | (ctl.a_inf & ctl.b_inf & (ctl.a_pos != bpe));
          inf = !nan & (ctl.a_inf | ctl.b_inf);
          pos = ctl.b_inf ? bpe : ctl.a_pos;
        end else if (ctl.a_pos == bpe) begin
          inf = sum[W];
          mag = sum[W-1:0];
        end else if (a_lt_b) begin
          pos = !ctl.a_pos;
          mag = b_mag - a_mag;
        end else begin
          mag = a_mag - b_mag;
        end
      end
      OP_MUL: begin
        pos = (ctl.a_pos == ctl.b_pos);
        if (any_flag) begin
          nan = ctl.a_nan | ctl.b_nan | (ctl.a_inf & b_zero) | (a_zero & ctl.b_inf);
          inf = !nan & (ctl.a_inf | ctl.b_inf);
        end else begin
          inf = prod_ovf;
          mag = prod;
        end
      end
      OP_DIV: begin
        pos = (ctl.a_pos == ctl.b_pos);
        if (any_flag || b_zero) begin
          nan = ctl.a_nan | ctl.b_nan | (ctl.a_inf & ctl.b_inf) | (a_zero & b_zero);
          inf = !nan & (ctl.a_inf | (!a_zero & b_zero));
          mag = '0;
        end else begin
          mag = quot;
        end
      end
      default: begin
        nan = 1'b1;
      end
    endcase
  end

  // Final fields, including compare and unknown opcodes.
  always_comb begin
    r_mag = '0;
    r_pos = 1'b0;
    r_nan = 1'b0;
    r_inf = 1'b0;
    order = ORD_LESS;
    if (ctl.op == OP_CMP) begin
      if (ctl.a_nan || ctl.b_nan) begin
        order = ORD_UNORDERED;
      end else if (ctl.a_inf && ctl.b_inf && (ctl.a_pos == ctl.b_pos)) begin
        order = ORD_EQUAL;
      end else if (ctl.a_pos != ctl.b_pos) begin
        order = ctl.a_pos ? ORD_GREATER : ORD_LESS;
      end else if (ctl.a_inf != ctl.b_inf) begin
        order = (ctl.a_inf == ctl.a_pos) ? ORD_GREATER : ORD_LESS;
      end else if (a_mag == b_mag) begin
        order = ORD_EQUAL;
      end else begin
        order = ((!a_lt_b) == ctl.a_pos) ? ORD_GREATER : ORD_LESS;
      end
    end else if (ctl.op > OP_CMP) begin
      r_pos = 1'b1;
      r_nan = 1'b1;
      order = ORD_UNORDERED;
    end else if (nan) begin
      r_pos = 1'b1;
      r_nan = 1'b1;
    end else if (inf) begin
      r_pos = pos;
      r_inf = 1'b1;
    end else begin
      r_mag = mag;
      r_pos = pos;
    end
  end

endmodule

// ----- design/sign_magnitude_saturating_alu.sv -----
// Sign-magnitude ALU with NaN and infinity flags: add, subtract, multiply,
// divide and compare on MAG_BITS-bit magnitudes (upper port bits ignored).
// Operands pass through a row of MAG_BITS cells; each cell does one
// shift-and-add multiply step and one restoring divide step, then a final
// stage resolves add, compare and the special values into an output
// register. One item is accepted per cycle unless backpressure holds
// the row; each result is registered in every cell and then in the
// output register. Backpressure stalls only the stages that are full.
module sign_magnitude_saturating_alu #(
  parameter int unsigned MAG_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [63:0] in_a_mag,
  input  logic        in_a_pos,
  input  logic        in_a_nan,
  input  logic        in_a_inf,
  input  logic [63:0] in_b_mag,
  input  logic        in_b_pos,
  input  logic        in_b_nan,
  input  logic        in_b_inf,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_r_mag,
  output logic        out_r_pos,
  output logic        out_r_nan,
  output logic        out_r_inf,
  output logic [1:0]  out_order
);
  import sma_pkg::*;

  localparam int unsigned W = MAG_BITS;

  logic               vld   [W+1];
  logic               rdy   [W+1];
  sma_ctl_t           ctl   [W+1];
  logic [W-1:0]       a     [W+1];
  logic [W-1:0]       b     [W+1];
  logic [W-1:0]       acc   [W+1];
  logic [W-1:0]       q     [W+1];
  logic [W-1:0]       ash   [W+1];
  logic               shovf [W+1];
  logic               ovf   [W+1];

  logic [W-1:0]       f_mag;
  logic               f_pos, f_nan, f_inf;
  logic [1:0]         f_order;
  logic               out_valid_r;
  logic [W-1:0]       r_mag_r;
  logic               r_pos_r, r_nan_r, r_inf_r;
  logic [1:0]         order_r;
  logic               out_take;

  // Row entry: operands masked to the magnitude width.
  assign vld[0]   = in_valid;
  assign in_ready = rdy[0];
  assign ctl[0]   = '{op: in_op, a_pos: in_a_pos, a_nan: in_a_nan, a_inf: in_a_inf,
                      b_pos: in_b_pos, b_nan: in_b_nan, b_inf: in_b_inf};
  assign a[0]     = in_a_mag[W-1:0];
  assign b[0]     = in_b_mag[W-1:0];
  assign acc[0]   = '0;
  assign q[0]     = '0;
  assign ash[0]   = in_a_mag[W-1:0];
  assign shovf[0] = 1'b0;
  assign ovf[0]   = 1'b0;

  // Row of cells, one magnitude bit each.
  for (genvar i = 0; i < W; i++) begin : g_cell
    sma_cell #(.W(W), .IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (vld[i]),
      .up_ready  (rdy[i]),
      .up_ctl    (ctl[i]),
      .up_a      (a[i]),
      .up_b      (b[i]),
      .up_acc    (acc[i]),
      .up_q      (q[i]),
      .up_ash    (ash[i]),
      .up_sh_ovf (shovf[i]),
      .up_ovf    (ovf[i]),
      .dn_valid  (vld[i+1]),
      .dn_ready  (rdy[i+1]),
      .dn_ctl    (ctl[i+1]),
      .dn_a      (a[i+1]),
      .dn_b      (b[i+1]),
      .dn_acc    (acc[i+1]),
      .dn_q      (q[i+1]),
      .dn_ash    (ash[i+1]),
      .dn_sh_ovf (shovf[i+1]),
      .dn_ovf    (ovf[i+1])
    );
  end

  // Final resolution of the item leaving the row.
  sma_fin #(.W(W)) u_fin (
    .ctl      (ctl[W]),
    .a_mag    (a[W]),
    .b_mag    (b[W]),
    .prod     (acc[W]),
    .prod_ovf (ovf[W]),
    .quot     (q[W]),
    .r_mag    (f_mag),
    .r_pos    (f_pos),
    .r_nan    (f_nan),
    .r_inf    (f_inf),
    .order    (f_order)
  );

  // Output register.
  assign rdy[W]   = !out_valid_r || out_ready;
  assign out_take = rdy[W] && vld[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[W]) begin
      out_valid_r <= vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      r_mag_r <= f_mag;
      r_pos_r <= f_pos;
      r_nan_r <= f_nan;
      r_inf_r <= f_inf;
      order_r <= f_order;
    end
  end

  assign out_valid = out_valid_r;
  assign out_r_mag = PORT_BITS'(r_mag_r);
  assign out_r_pos = r_pos_r;
  assign out_r_nan = r_nan_r;
  assign out_r_inf = r_inf_r;
  assign out_order = order_r;

endmodule
